### hdl/ssp_pkg.sv
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types and codes for the servo status packet parser.
// ----------------------------------------------------------------------------
package ssp_pkg;

    localparam logic [7:0]  SYNC_BYTE     = 8'hFF;
    localparam logic [19:0] TIMEOUT_RESET = 20'h51615;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // register index (paddr[3:2])
    localparam logic [1:0] REG_EXPECTED_ID   = 2'd0;
    localparam logic [1:0] REG_PARAM_COUNT   = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_LIMIT = 2'd2;

    // input op codes
    localparam logic [1:0] OP_ARM  = 2'd0;
    localparam logic [1:0] OP_BYTE = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // parser phases
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_HUNT1 = 3'd1;
    localparam logic [2:0] PH_HUNT2 = 3'd2;
    localparam logic [2:0] PH_ID    = 3'd3;
    localparam logic [2:0] PH_LEN   = 3'd4;
    localparam logic [2:0] PH_ERR   = 3'd5;
    localparam logic [2:0] PH_PARAM = 3'd6;
    localparam logic [2:0] PH_CSUM  = 3'd7;

    // packet status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_TIMEOUT  = 3'd1;
    localparam logic [2:0] ST_ID       = 3'd2;
    localparam logic [2:0] ST_LENGTH   = 3'd3;
    localparam logic [2:0] ST_DEVERR   = 3'd4;
    localparam logic [2:0] ST_CHECKSUM = 3'd5;

    typedef struct packed {
        logic [7:0]  expected_id;
        logic [7:0]  param_count;
        logic [19:0] timeout_limit;
    } cfg_t;

    typedef struct packed {
        logic        is_status;
        logic [7:0]  param_byte;
        logic [7:0]  param_index;
        logic [2:0]  status;
        logic [7:0]  device_error;
    } res_t;

endpackage

### hdl/servo_status_packet_parser.sv
// ----------------------------------------------------------------------------
// servo_status_packet_parser
// Servo-bus status packet parser with APB-style configuration.
// ----------------------------------------------------------------------------
// Each word is an arm, a received byte or a time tick. A word is taken into an
// input register, parsed against the packet state, and any result lands in an
// output register, so the block sustains one word per clock unless the output
// stalls. Parameter bytes stream out with their index before the closing
// status word; keep them only if the status is ok. Write the registers only
// while no packet is in flight.
module servo_status_packet_parser (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ssp_pkg::ADDR_W-1:0] paddr,
    input  logic [ssp_pkg::DATA_W-1:0] pwdata,
    output logic [ssp_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 op,
    input  logic [7:0]                 rx_byte,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       is_status,
    output logic [7:0]                 param_byte,
    output logic [7:0]                 param_index,
    output logic [2:0]                 status,
    output logic [7:0]                 device_error
);
    import ssp_pkg::*;

    cfg_t cfg;
    res_t res;
    res_t out_res;
    logic res_valid;
    logic out_free;

    ssp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ssp_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .rx_byte   (rx_byte),
        .cfg       (cfg),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    ssp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res       (res),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign is_status    = out_res.is_status;
    assign param_byte   = out_res.param_byte;
    assign param_index  = out_res.param_index;
    assign status       = out_res.status;
    assign device_error = out_res.device_error;

endmodule

### hdl/ssp_regs.sv
// ----------------------------------------------------------------------------
// ssp_regs
// APB-style configuration registers: expected ID, parameter count, timeout.
// ----------------------------------------------------------------------------
module ssp_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ssp_pkg::ADDR_W-1:0] paddr,
    input  logic [ssp_pkg::DATA_W-1:0] pwdata,
    output logic [ssp_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output ssp_pkg::cfg_t              cfg
);
    import ssp_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_EXPECTED_ID:   cfg_next.expected_id   = pwdata[7:0];
                REG_PARAM_COUNT:   cfg_next.param_count   = pwdata[7:0];
                REG_TIMEOUT_LIMIT: cfg_next.timeout_limit = pwdata[19:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_EXPECTED_ID:   prdata = {24'd0, cfg_reg.expected_id};
            REG_PARAM_COUNT:   prdata = {24'd0, cfg_reg.param_count};
            REG_TIMEOUT_LIMIT: prdata = {12'd0, cfg_reg.timeout_limit};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_id   <= 8'd0;
            cfg_reg.param_count   <= 8'd0;
            cfg_reg.timeout_limit <= TIMEOUT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hdl/ssp_engine.sv
// ----------------------------------------------------------------------------
// ssp_engine
// Input word register and the packet parse state; one word per cycle while the output stage has room.
// ----------------------------------------------------------------------------
module ssp_engine (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    op,
    input  logic [7:0]    rx_byte,
    input  ssp_pkg::cfg_t cfg,
    input  logic          out_free,
    output logic          res_valid,
    output ssp_pkg::res_t res
);
    import ssp_pkg::*;

    logic        item_valid_reg, item_valid_next;
    logic [1:0]  op_reg;
    logic [7:0]  byte_reg;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [19:0] idle_reg, idle_next;
    logic [7:0]  err_reg, err_next;

    logic        advance;
    logic        take;
    logic [7:0]  cnt_inc;
    logic [8:0]  len_expect;

    assign advance    = item_valid_reg && out_free;
    assign in_ready   = !item_valid_reg || out_free;
    assign take       = in_valid && in_ready;
    assign cnt_inc    = cnt_reg + 8'd1;
    assign len_expect = {1'b0, cfg.param_count} + 9'd2;

    always_comb
    begin
        if (take)
            item_valid_next = 1'b1;
        else if (advance)
            item_valid_next = 1'b0;
        else
            item_valid_next = item_valid_reg;
    end

    always_comb
    begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        idle_next  = idle_reg;
        err_next   = err_reg;
        res_valid  = 1'b0;
        res        = '0;

        if (advance)
        begin
            if (op_reg == OP_ARM)
            begin
                phase_next = PH_HUNT1;
                sum_next   = 8'd0;
                cnt_next   = 8'd0;
                idle_next  = 20'd0;
                err_next   = 8'd0;
            end
            else if (phase_reg != PH_IDLE && op_reg == OP_TICK)
            begin
                if (idle_reg >= cfg.timeout_limit)
                begin
                    res_valid        = 1'b1;
                    res.is_status    = 1'b1;
                    res.status       = ST_TIMEOUT;
                    res.device_error = err_reg;
                    phase_next       = PH_IDLE;
                end
                else
                begin
                    idle_next = idle_reg + 20'd1;
                end
            end
            else if (phase_reg != PH_IDLE && op_reg == OP_BYTE)
            begin
                idle_next = 20'd0;
                case (phase_reg)
                    PH_HUNT1:
                    begin
                        if (byte_reg == SYNC_BYTE)
                            phase_next = PH_HUNT2;
                    end
                    PH_HUNT2:
                    begin
                        phase_next = (byte_reg == SYNC_BYTE) ? PH_ID : PH_HUNT1;
                    end
                    PH_ID:
                    begin
                        if (byte_reg != cfg.expected_id)
                        begin
                            res_valid        = 1'b1;
                            res.is_status    = 1'b1;
                            res.status       = ST_ID;
                            res.device_error = err_reg;
                            phase_next       = PH_IDLE;
                        end
                        else
                        begin
                            sum_next   = byte_reg;
                            phase_next = PH_LEN;
                        end
                    end
                    PH_LEN:
                    begin
                        // compared without wrap: count above 253 never matches
                        if ({1'b0, byte_reg} != len_expect)
                        begin
                            res_valid        = 1'b1;
                            res.is_status    = 1'b1;
                            res.status       = ST_LENGTH;
                            res.device_error = err_reg;
                            phase_next       = PH_IDLE;
                        end
                        else
                        begin
                            sum_next   = sum_reg + byte_reg;
                            phase_next = PH_ERR;
                        end
                    end
                    PH_ERR:
                    begin
                        err_next = byte_reg;
                        if (byte_reg != 8'd0)
                        begin
                            res_valid        = 1'b1;
                            res.is_status    = 1'b1;
                            res.status       = ST_DEVERR;
                            res.device_error = byte_reg;
                            phase_next       = PH_IDLE;
                        end
                        else
                        begin
                            cnt_next   = 8'd0;
                            phase_next = (cfg.param_count == 8'd0) ? PH_CSUM : PH_PARAM;
                        end
                    end
                    PH_PARAM:
                    begin
                        sum_next        = sum_reg + byte_reg;
                        cnt_next        = cnt_inc;
                        res_valid       = 1'b1;
                        res.param_byte  = byte_reg;
                        res.param_index = cnt_reg;
                        if (cnt_inc >= cfg.param_count)
                            phase_next = PH_CSUM;
                    end
                    PH_CSUM:
                    begin
                        res_valid        = 1'b1;
                        res.is_status    = 1'b1;
                        res.status       = (byte_reg == ~sum_reg) ? ST_OK : ST_CHECKSUM;
                        res.device_error = err_reg;
                        phase_next       = PH_IDLE;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg   <= op;
            byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            phase_reg      <= PH_IDLE;
            sum_reg        <= 8'd0;
            cnt_reg        <= 8'd0;
            idle_reg       <= 20'd0;
            err_reg        <= 8'd0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            phase_reg      <= phase_next;
            sum_reg        <= sum_next;
            cnt_reg        <= cnt_next;
            idle_reg       <= idle_next;
            err_reg        <= err_next;
        end
    end

endmodule

### hdl/ssp_out_stage.sv
// ----------------------------------------------------------------------------
// ssp_out_stage
// Result register; holds a word until the consumer takes it.
// ----------------------------------------------------------------------------
module ssp_out_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  ssp_pkg::res_t res,
    output logic          out_free,
    output logic          out_valid,
    input  logic          out_ready,
    output ssp_pkg::res_t out_res
);
    import ssp_pkg::*;

    logic valid_reg, valid_next;
    res_t res_reg;

    assign out_free  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

endmodule

### hdl/ssp_checker.sv
// ----------------------------------------------------------------------------
// ssp_checker
// Port-level checks on the result channel of the parser.
// ----------------------------------------------------------------------------
module ssp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       is_status,
    input logic [7:0] param_byte,
    input logic [7:0] param_index,
    input logic [2:0] status,
    input logic [7:0] device_error
);
    import ssp_pkg::*;

    // stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(is_status)
            && $stable(param_byte) && $stable(param_index)
            && $stable(status) && $stable(device_error))
        else $error("result word changed while stalled");

    a_param_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_status |-> status == ST_OK && device_error == 8'd0)
        else $error("parameter word carries status fields");

    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_status |-> param_byte == 8'd0 && param_index == 8'd0)
        else $error("status word carries parameter fields");

    a_ok_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_status && (status == ST_OK || status == ST_CHECKSUM)
            |-> device_error == 8'd0)
        else $error("packet past error check reports device error");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_status |-> status <= ST_CHECKSUM)
        else $error("status code out of range");

endmodule

bind servo_status_packet_parser ssp_checker u_ssp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .is_status    (is_status),
    .param_byte   (param_byte),
    .param_index  (param_index),
    .status       (status),
    .device_error (device_error)
);

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the servo status packet parser. Packets are built
// with random content and a few deliberate faults (bad ID, length, device
// error or checksum, timeouts, abandoned packets, line noise). A word-level
// parser model predicts every output word, and a scoreboard compares each
// output word field by field. The registers are rewritten between phases
// while the block is idle. Both handshake sides get random gaps.
// ----------------------------------------------------------------------------
module tb_top;
    import ssp_pkg::*;

    localparam logic [1:0] OP_NONE        = 2'd3;   // unused code, the parser drops it
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         TAIL_CYCLES    = 6;

    typedef struct packed {
        logic [1:0] code;
        logic [7:0] data;
    } word_t;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [ADDR_W-1:0]   paddr       = '0;
    logic [DATA_W-1:0]   pwdata      = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid    = 1'b0;
    logic                in_ready;
    logic [1:0]          op          = OP_ARM;
    logic [7:0]          rx_byte     = 8'd0;
    logic                out_valid;
    logic                out_ready   = 1'b0;
    logic                is_status;
    logic [7:0]          param_byte;
    logic [7:0]          param_index;
    logic [2:0]          status;
    logic [7:0]          device_error;

    servo_status_packet_parser dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // register shadow and parser model state
    cfg_t        cfg;
    logic [2:0]  pkt_phase;
    logic [7:0]  chk_sum;
    logic [7:0]  par_idx;
    logic [19:0] idle_cnt;
    logic [7:0]  err_seen;

    word_t       stim_q[$];
    res_t        pending_out_q[$];
    int          words_left;
    int          words_total;
    int          out_cnt;
    int          verdict_cnt;
    int          ok_cnt;
    int          mismatches;
    int          settings_cnt;
    bit          no_idle;

    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic bit close_packet(input logic [2:0] st, output res_t r);
        r              = '0;
        r.is_status    = 1'b1;
        r.status       = st;
        r.device_error = err_seen;
        pkt_phase      = PH_IDLE;
        return 1'b1;
    endfunction

    // one word through the parser model; returns 1 when it yields an output word
    function automatic bit parse_word(input logic [1:0] code, input logic [7:0] b,
                                      output res_t r);
        r = '0;
        if (code == OP_ARM)
        begin
            pkt_phase = PH_HUNT1;
            chk_sum   = '0;
            par_idx   = '0;
            idle_cnt  = '0;
            err_seen  = '0;
            return 1'b0;
        end
        if (pkt_phase == PH_IDLE || code == OP_NONE)
            return 1'b0;
        if (code == OP_TICK)
        begin
            if (idle_cnt >= cfg.timeout_limit)
                return close_packet(ST_TIMEOUT, r);
            idle_cnt = idle_cnt + 20'd1;
            return 1'b0;
        end
        idle_cnt = '0;
        case (pkt_phase)
            PH_HUNT1:
                if (b == SYNC_BYTE)
                    pkt_phase = PH_HUNT2;
            PH_HUNT2:
                pkt_phase = (b == SYNC_BYTE) ? PH_ID : PH_HUNT1;
            PH_ID:
            begin
                if (b != cfg.expected_id)
                    return close_packet(ST_ID, r);
                chk_sum   = b;
                pkt_phase = PH_LEN;
            end
            PH_LEN:
            begin
                // compared without wrap, so counts above 253 never match
                if ({1'b0, b} != {1'b0, cfg.param_count} + 9'd2)
                    return close_packet(ST_LENGTH, r);
                chk_sum   = chk_sum + b;
                pkt_phase = PH_ERR;
            end
            PH_ERR:
            begin
                err_seen = b;
                if (b != 8'd0)
                    return close_packet(ST_DEVERR, r);
                par_idx   = '0;
                pkt_phase = (cfg.param_count == 8'd0) ? PH_CSUM : PH_PARAM;
            end
            PH_PARAM:
            begin
                r.param_byte  = b;
                r.param_index = par_idx;
                chk_sum       = chk_sum + b;
                par_idx       = par_idx + 8'd1;
                if (par_idx >= cfg.param_count)
                    pkt_phase = PH_CSUM;
                return 1'b1;
            end
            PH_CSUM:
                return close_packet((b == ~chk_sum) ? ST_OK : ST_CHECKSUM, r);
            default:
                pkt_phase = PH_IDLE;
        endcase
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("out word %0d: %s = 0x%0h, expected 0x%0h",
                                      out_cnt, name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // driver: feeds stim_q into the input channel and runs the model on accept
    // ------------------------------------------------------------------------
    int in_gap;

    always @(posedge clk)
    begin : drive_in
        res_t  r;
        word_t w;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (parse_word(op, rx_byte, r))
                    pending_out_q.push_back(r);
                words_left--;
            end
            if (!(in_valid && !in_ready))
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (stim_q.size() > 0)
                begin
                    w        = stim_q.pop_front();
                    in_valid <= 1'b1;
                    op       <= w.code;
                    rx_byte  <= w.data;
                    in_gap   = next_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: scoreboard on the output channel, random backpressure
    // ------------------------------------------------------------------------
    int out_stall;

    always @(posedge clk)
    begin : watch_out
        res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_out_q.size() == 0)
            begin
                report_mismatch($sformatf("out word %0d arrived with nothing expected",
                                          out_cnt));
            end
            else
            begin
                want = pending_out_q.pop_front();
                check_field("is_status",    8'(is_status),   8'(want.is_status));
                check_field("param_byte",   param_byte,      want.param_byte);
                check_field("param_index",  param_index,     want.param_index);
                check_field("status",       8'(status),      8'(want.status));
                check_field("device_error", device_error,    want.device_error);
                if (want.is_status)
                begin
                    verdict_cnt++;
                    if (want.status == ST_OK)
                        ok_cnt++;
                end
            end
            out_cnt++;
        end
        if (out_stall > 0)
        begin
            out_stall--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            out_stall = next_gap();
        end
    end

    int stuck_cycles;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            stuck_cycles = 0;
        end
        else
        begin
            stuck_cycles++;
            if (stuck_cycles == WATCHDOG_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles, %0d output words owed",
                         WATCHDOG_LIMIT, pending_out_q.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic push_word(input logic [1:0] code, input logic [7:0] b);
        word_t w;
        w.code = code;
        w.data = b;
        stim_q.push_back(w);
        words_left++;
        words_total++;
    endtask

    // a received byte, sometimes preceded by idle ticks that stay under the limit
    task automatic push_byte(input logic [7:0] b);
        int lim;
        lim = cfg.timeout_limit;
        if (lim != 0 && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, (lim > 3) ? 3 : lim))
                push_word(OP_TICK, 8'($urandom));
        push_word(OP_BYTE, b);
    endtask

    task automatic queue_packet();
        int         kind;
        logic [7:0] s;
        logic [7:0] v;
        kind = $urandom_range(0, 9);
        if (cfg.param_count > 8'd16)
            kind = ($urandom_range(0, 3) == 0) ? 7 : 0;
        if (kind == 8 && cfg.timeout_limit > 20'd40)
            kind = 0;
        push_word(OP_ARM, 8'($urandom));
        repeat ($urandom_range(0, 2))
            push_byte(8'($urandom_range(0, 254)));
        if ($urandom_range(0, 3) == 0)
        begin
            // lone sync byte, the hunt must start over
            push_byte(SYNC_BYTE);
            push_byte(8'($urandom_range(0, 254)));
        end
        push_byte(SYNC_BYTE);
        push_byte(SYNC_BYTE);
        if (kind == 8)
        begin
            repeat (cfg.timeout_limit + 1)
                push_word(OP_TICK, 8'($urandom));
            return;
        end
        if (kind == 9)
        begin
            // partial packet plus line noise; the next arm drops it
            repeat ($urandom_range(1, 4))
                push_word(2'($urandom_range(1, 3)), 8'($urandom));
            return;
        end
        v = cfg.expected_id;
        if (kind == 4)
            v = v ^ 8'($urandom_range(1, 255));
        push_byte(v);
        if (kind == 4)
            return;
        s = v;
        v = cfg.param_count + 8'd2;
        if (kind == 5)
            v = v + 8'($urandom_range(1, 255));
        push_byte(v);
        s = s + v;
        // a count above 253 always fails the length check, the rest is dead
        if (kind == 5 || cfg.param_count > 8'd253)
            return;
        v = (kind == 6) ? 8'($urandom_range(1, 255)) : 8'd0;
        push_byte(v);
        if (kind == 6)
            return;
        repeat (cfg.param_count)
        begin
            v = 8'($urandom);
            push_byte(v);
            s = s + v;
        end
        v = ~s;
        if (kind == 7)
            v = v ^ 8'($urandom_range(1, 255));
        push_byte(v);
        if ($urandom_range(0, 3) == 0)
            push_word(($urandom_range(0, 1) == 0) ? OP_BYTE : OP_NONE, 8'($urandom));
    endtask

    task automatic wait_idle();
        while (words_left != 0 || pending_out_q.size() != 0)
            @(posedge clk);
        // words that give no output may still be in the pipeline
        repeat (TAIL_CYCLES)
            @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_phase(input logic [7:0] id, input logic [7:0] cnt,
                             input logic [19:0] lim, input int budget);
        int start;
        wait_idle();
        apb_write(REG_EXPECTED_ID, DATA_W'(id));
        apb_write(REG_PARAM_COUNT, DATA_W'(cnt));
        apb_write(REG_TIMEOUT_LIMIT, DATA_W'(lim));
        cfg.expected_id   = id;
        cfg.param_count   = cnt;
        cfg.timeout_limit = lim;
        settings_cnt++;
        no_idle = ($urandom_range(0, 3) == 0);
        start   = words_total;
        while (words_total - start < budget)
            queue_packet();
    endtask

    initial
    begin
        cfg.expected_id   = 8'd0;
        cfg.param_count   = 8'd0;
        cfg.timeout_limit = TIMEOUT_RESET;
        pkt_phase         = PH_IDLE;
        chk_sum           = '0;
        par_idx           = '0;
        idle_cnt          = '0;
        err_seen          = '0;
        settings_cnt      = 1;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset register values: good packet with no parameters
        push_word(OP_ARM, 8'h00);
        push_word(OP_BYTE, 8'hFF);  push_word(OP_BYTE, 8'hFF);
        push_word(OP_BYTE, 8'h00);  push_word(OP_BYTE, 8'h02);
        push_word(OP_BYTE, 8'h00);  push_word(OP_BYTE, 8'hFD);
        // traffic while not armed
        push_word(OP_BYTE, 8'h55);  push_word(OP_TICK, 8'hAA);
        push_word(OP_NONE, 8'hFF);
        // lone sync, then 0xFF taken as the ID after the pair
        push_word(OP_ARM, 8'hFF);
        push_word(OP_BYTE, 8'hFF);  push_word(OP_BYTE, 8'h12);
        push_word(OP_BYTE, 8'hFF);  push_word(OP_BYTE, 8'hFF);
        push_word(OP_BYTE, 8'hFF);
        // re-arm mid packet, then a bad length
        push_word(OP_ARM, 8'h00);
        push_word(OP_BYTE, 8'hFF);  push_word(OP_BYTE, 8'hFF);
        push_word(OP_ARM, 8'h00);   push_word(OP_NONE, 8'h00);
        push_word(OP_BYTE, 8'hFF);  push_word(OP_BYTE, 8'hFF);
        push_word(OP_BYTE, 8'h00);  push_word(OP_BYTE, 8'h07);
        // device error
        push_word(OP_ARM, 8'h00);
        push_word(OP_BYTE, 8'hFF);  push_word(OP_BYTE, 8'hFF);
        push_word(OP_BYTE, 8'h00);  push_word(OP_BYTE, 8'h02);
        push_word(OP_BYTE, 8'h80);

        run_phase(8'hFF, 8'd0, 20'd0, 40);
        run_phase(8'h01, 8'd3, 20'd1, 40);
        run_phase(8'h5A, 8'd120, 20'hFFFFF, 1);
        run_phase(8'($urandom), 8'd255, 20'd5, 20);
        repeat (4)
            run_phase(8'($urandom), 8'($urandom_range(0, 8)),
                      20'($urandom_range(1, 6)), 15);
        wait_idle();

        $display("Drove %0d input words across %0d register settings.",
                 words_total, settings_cnt);
        $display("Checked %0d output words: %0d packet verdicts, %0d of them ok.",
                 out_cnt, verdict_cnt, ok_cnt);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
